[rtl/core/ascii_number_parser_macros.svh]
// ----------------------------------------------------------------------------
// ascii_number_parser_macros.svh
// Assertion macros shared by the number parser RTL.
// ----------------------------------------------------------------------------
`ifndef ASCII_NUMBER_PARSER_MACROS_SVH
`define ASCII_NUMBER_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ANP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define ANP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/anp_pkg.sv]
// ----------------------------------------------------------------------------
// anp_pkg
// Types, character codes and helper functions for the number parser.
// ----------------------------------------------------------------------------
`default_nettype none

package anp_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned POS_W   = 2;

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_F = 8'h46;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_H = 8'h48;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_X = 8'h58;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_TILDE   = 8'h7E;
    localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;
    localparam logic [CHAR_W-1:0] LETTER_GAP   = 8'd7;
    localparam logic [DIGIT_W-1:0] DIGIT_MASK  = 4'hF;

    // Character position within the string, saturating at the last code
    localparam logic [POS_W-1:0] POS_FIRST  = 2'd0;
    localparam logic [POS_W-1:0] POS_SECOND = 2'd1;
    localparam logic [POS_W-1:0] POS_THIRD  = 2'd2;
    localparam logic [POS_W-1:0] POS_REST   = 2'd3;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              is_last;
    } anp_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               was_hex;
    } anp_result_t;

    function automatic logic [CHAR_W-1:0] fold_upper(input logic [CHAR_W-1:0] ch);
        logic [CHAR_W-1:0] folded;
        folded = ch;
        if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
            folded = ch - CASE_OFFSET;
        end
        return folded;
    endfunction

    function automatic logic [DIGIT_W-1:0] digit_value(input logic [CHAR_W-1:0] ch);
        logic [CHAR_W-1:0] adj;
        adj = ch;
        if (ch > CHAR_NINE) begin
            adj = ch - LETTER_GAP;
        end
        return adj[DIGIT_W-1:0] & DIGIT_MASK;
    endfunction

endpackage

`default_nettype wire

[rtl/core/anp_core.sv]
// ----------------------------------------------------------------------------
// anp_core
// Decimal and hex accumulators plus prefix flags; forms the result for the
// last character of a string and clears itself afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module anp_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               step,
    input  wire anp_pkg::anp_item_t item,
    output anp_pkg::anp_result_t    result
);

    logic [anp_pkg::VALUE_W-1:0] dec_sum_reg, dec_sum_next;
    logic [anp_pkg::VALUE_W-1:0] hex_sum_reg, hex_sum_next;
    logic [anp_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic first_zero_reg, first_zero_next;
    logic first_tilde_reg, first_tilde_next;
    logic second_x_reg, second_x_next;
    logic second_zero_reg, second_zero_next;
    logic third_x_reg, third_x_next;

    logic [anp_pkg::CHAR_W-1:0]  ch;
    logic [anp_pkg::DIGIT_W-1:0] digit;
    logic                        is_dec;
    logic                        is_hex;
    logic [anp_pkg::VALUE_W-1:0] dec_acc;
    logic [anp_pkg::VALUE_W-1:0] hex_acc;
    logic                        hex_base;
    logic [anp_pkg::VALUE_W-1:0] chosen;

    always_comb begin
        ch     = anp_pkg::fold_upper(item.char_code);
        digit  = anp_pkg::digit_value(ch);
        is_dec = (ch >= anp_pkg::CHAR_ZERO) && (ch <= anp_pkg::CHAR_NINE);
        is_hex = is_dec || ((ch >= anp_pkg::CHAR_UPPER_A) && (ch <= anp_pkg::CHAR_UPPER_F));

        // x*10 as x*8 + x*2, x*16 as a shift
        dec_acc = is_dec ? ((dec_sum_reg << 3) + (dec_sum_reg << 1)
                            + {{(anp_pkg::VALUE_W-anp_pkg::DIGIT_W){1'b0}}, digit})
                         : dec_sum_reg;
        hex_acc = is_hex ? {hex_sum_reg[anp_pkg::VALUE_W-anp_pkg::DIGIT_W-1:0], digit}
                         : hex_sum_reg;

        first_zero_next  = first_zero_reg;
        first_tilde_next = first_tilde_reg;
        second_x_next    = second_x_reg;
        second_zero_next = second_zero_reg;
        third_x_next     = third_x_reg;
        pos_next         = pos_reg;
        unique case (pos_reg)
            anp_pkg::POS_FIRST: begin
                first_zero_next  = (ch == anp_pkg::CHAR_ZERO);
                first_tilde_next = (ch == anp_pkg::CHAR_TILDE);
                pos_next         = anp_pkg::POS_SECOND;
            end
            anp_pkg::POS_SECOND: begin
                second_x_next    = (ch == anp_pkg::CHAR_UPPER_X);
                second_zero_next = (ch == anp_pkg::CHAR_ZERO);
                pos_next         = anp_pkg::POS_THIRD;
            end
            anp_pkg::POS_THIRD: begin
                third_x_next = (ch == anp_pkg::CHAR_UPPER_X);
                pos_next     = anp_pkg::POS_REST;
            end
            anp_pkg::POS_REST: begin
                pos_next = anp_pkg::POS_REST;
            end
            default: begin
                pos_next = anp_pkg::POS_REST;
            end
        endcase

        hex_base = (ch == anp_pkg::CHAR_UPPER_H)
                || (first_zero_next && second_x_next)
                || (first_tilde_next && second_zero_next && third_x_next);
        chosen = hex_base ? hex_acc : dec_acc;
        result.value   = first_tilde_next ? ~chosen : chosen;
        result.was_hex = hex_base;

        dec_sum_next = dec_acc;
        hex_sum_next = hex_acc;
        // Clear everything once the string's result has been formed
        if (item.is_last) begin
            dec_sum_next     = '0;
            hex_sum_next     = '0;
            pos_next         = anp_pkg::POS_FIRST;
            first_zero_next  = 1'b0;
            first_tilde_next = 1'b0;
            second_x_next    = 1'b0;
            second_zero_next = 1'b0;
            third_x_next     = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_sum_reg     <= '0;
            hex_sum_reg     <= '0;
            pos_reg         <= anp_pkg::POS_FIRST;
            first_zero_reg  <= 1'b0;
            first_tilde_reg <= 1'b0;
            second_x_reg    <= 1'b0;
            second_zero_reg <= 1'b0;
            third_x_reg     <= 1'b0;
        end else if (step) begin
            dec_sum_reg     <= dec_sum_next;
            hex_sum_reg     <= hex_sum_next;
            pos_reg         <= pos_next;
            first_zero_reg  <= first_zero_next;
            first_tilde_reg <= first_tilde_next;
            second_x_reg    <= second_x_next;
            second_zero_reg <= second_zero_next;
            third_x_reg     <= third_x_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/ascii_number_parser.sv]
// ----------------------------------------------------------------------------
// ascii_number_parser
// Converts a decimal or hex ASCII string, one character per transfer, into a
// 32-bit value; one result per string.
// ----------------------------------------------------------------------------
//  channel | dir | signals                      | content
//  s_      | in  | s_tvalid s_tready s_tdata    | char_code, s_tlast = is_last
//          |     | s_tlast                      |
//  m_      | out | m_tvalid m_tready m_tdata    | value; m_tuser = was_hex
//          |     | m_tuser                      |
//
//  One character per cycle unless a last character is stalled; the result is
//  presented after the last character passes the input and result registers.
//  Reset: aresetn low at a clock edge clears all control state and sums.
//  A stalled result holds only a following last character, and the input
//  waits behind it; other characters keep flowing into the accumulators.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ascii_number_parser_macros.svh"

module ascii_number_parser (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tlast,   // is_last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] value
    output logic [0:0]       m_tuser    // [0] was_hex
);

    logic                    in_valid_reg, in_valid_next;
    anp_pkg::anp_item_t      in_item_reg;
    logic                    out_valid_reg, out_valid_next;
    anp_pkg::anp_result_t    out_result_reg;
    anp_pkg::anp_result_t    core_result;

    logic s_accept;
    logic stall;
    logic step;
    logic out_load;

    // Hold a last character while the previous result still waits
    assign stall    = in_valid_reg && in_item_reg.is_last && out_valid_reg && !m_tready;
    assign step     = in_valid_reg && !stall;
    assign out_load = step && in_item_reg.is_last;
    assign s_tready = !in_valid_reg || !stall;
    assign s_accept = s_tvalid && s_tready;

    assign in_valid_next  = s_accept || (in_valid_reg && stall);
    assign out_valid_next = out_load || (out_valid_reg && !m_tready);

    anp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_item_reg),
        .result  (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.char_code <= s_tdata;
            in_item_reg.is_last   <= s_tlast;
        end
        if (out_load) begin
            out_result_reg <= core_result;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_result_reg.value;
    assign m_tuser[0] = out_result_reg.was_hex;

    `ANP_ASSERT_NOW(a_ready_low_needs_result, aclk, aresetn, !s_tready, m_tvalid, "input stalled without a pending result")
    `ANP_ASSERT_NEXT(a_last_gives_result, aclk, aresetn, out_load, m_tvalid, "last character produced no result")
    `ANP_ASSERT_NEXT(a_stall_keeps_item, aclk, aresetn, stall, in_valid_reg && in_item_reg.is_last, "stalled last character was dropped")

endmodule

`default_nettype wire
